>>> src/r2cov_pkg.sv
// Shared types and constants for the radius-2 coverage count engine.
// Used by r2cov_ctrl, r2cov_datapath and the top level; depends on nothing.
`default_nettype none

package r2cov_pkg;

    // Default geometry limits.
    localparam int MaxSyndromeBits = 16;
    localparam int MaxColumns      = 512;

    // Fixed field widths.
    localparam int ColumnW   = 16;
    localparam int SlotW     = 9;
    localparam int CountW    = 9;
    localparam int TotalW    = 17;
    localparam int LoadedW   = 10;
    localparam int ObjW      = 23;
    localparam int RedundW   = 5;
    localparam int ColCountW = 10;
    localparam int ModeW     = 3;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 10;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_REDUNDANCY     = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_COLUMN_COUNT   = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_OBJECTIVE_MODE = 2'd2;

    // Register reset values.
    localparam logic [RedundW-1:0]   RedundReset   = 5'd11;
    localparam logic [ColCountW-1:0] ColCountReset = 10'd78;
    localparam logic [ModeW-1:0]     ModeReset     = 3'd0;

    // Smallest syndrome width in use.
    localparam logic [RedundW-1:0] MinRedund = 5'd3;

    // Objective modes.
    localparam logic [ModeW-1:0] MODE_MISS_A   = 3'd0;
    localparam logic [ModeW-1:0] MODE_MISS_B   = 3'd3;
    localparam logic [ModeW-1:0] MODE_SCALE4_A = 3'd1;
    localparam logic [ModeW-1:0] MODE_SCALE4_B = 3'd4;
    localparam int ScaleLowShift  = 4;
    localparam int ScaleHighShift = 6;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_SWAP  = 2'd2,
        REQ_QUERY = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_BAD_COLUMN = 3'd1,
        STS_DUPLICATE  = 3'd2,
        STS_PHASE      = 3'd3,
        STS_BAD_SLOT   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_DECIDE,
        S_SELF_RD,
        S_SELF_WR,
        S_PAIR_RD,
        S_PAIR_WR,
        S_FLAG_CLR,
        S_FLAG_SET,
        S_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_req;
        logic clr_start;
        logic clr_step;
        logic chk_rd;
        logic decide;
        logic sweep_new;
        logic sweep_rem;
        logic cnt_rd_self;
        logic cnt_rd_pair;
        logic cnt_wr;
        logic idx_adv;
        logic flag_clr;
        logic flag_set;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic    clr_last;
        logic    pair_done;
        logic    phase_rem;
        logic    out_free;
        req_t    req;
        status_t code;
    } stat_t;

endpackage

`default_nettype wire

>>> src/r2cov_ctrl.sv
// Sequencing state machine of the coverage count engine.
// Depends on r2cov_pkg; drives the command struct of r2cov_datapath.
`default_nettype none

module r2cov_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  r2cov_pkg::stat_t  st,
    output r2cov_pkg::cmd_t   cmd
);
    import r2cov_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   reply_reg;
    logic   reply_next;

    // State and reply flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            reply_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            reply_reg <= reply_next;
        end
    end

    // A clear that follows a request ends with a result; the one after reset does not.
    always_comb
    begin
        reply_next = reply_reg;
        if (state_reg == S_IDLE && in_valid)
        begin
            reply_next = 1'b1;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:     state_next = S_CLEAR;
            S_CLEAR:
            begin
                if (st.clr_last)
                begin
                    state_next = reply_reg ? S_OUT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:    state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (st.req == REQ_CLEAR)
                begin
                    state_next = S_INIT;
                end
                else if (st.req == REQ_QUERY || st.code != STS_OK)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SELF_RD;
                end
            end
            S_SELF_RD:  state_next = S_SELF_WR;
            S_SELF_WR:  state_next = S_PAIR_RD;
            S_PAIR_RD:
            begin
                if (!st.pair_done)
                begin
                    state_next = S_PAIR_WR;
                end
                else if (st.phase_rem)
                begin
                    state_next = S_SELF_RD;
                end
                else if (st.req == REQ_SWAP)
                begin
                    state_next = S_FLAG_CLR;
                end
                else
                begin
                    state_next = S_FLAG_SET;
                end
            end
            S_PAIR_WR:  state_next = S_PAIR_RD;
            S_FLAG_CLR: state_next = S_FLAG_SET;
            S_FLAG_SET: state_next = S_OUT;
            S_OUT:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_INIT;
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_INIT:     cmd.clr_start = 1'b1;
            S_CLEAR:    cmd.clr_step  = 1'b1;
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.latch_req = in_valid;
            end
            S_CHECK:    cmd.chk_rd = 1'b1;
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (st.code == STS_OK)
                begin
                    cmd.sweep_new = (st.req == REQ_LOAD);
                    cmd.sweep_rem = (st.req == REQ_SWAP);
                end
            end
            S_SELF_RD:  cmd.cnt_rd_self = 1'b1;
            S_SELF_WR:  cmd.cnt_wr = 1'b1;
            S_PAIR_RD:
            begin
                cmd.cnt_rd_pair = !st.pair_done;
                cmd.sweep_new   = st.pair_done && st.phase_rem;
            end
            S_PAIR_WR:
            begin
                cmd.cnt_wr  = 1'b1;
                cmd.idx_adv = 1'b1;
            end
            S_FLAG_CLR: cmd.flag_clr = 1'b1;
            S_FLAG_SET: cmd.flag_set = 1'b1;
            S_OUT:      cmd.out_load = st.out_free;
            default:    cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> src/r2cov_datapath.sv
// Datapath of the coverage count engine: count, flag and column memories,
// running totals, sweep index and the result register. Depends on r2cov_pkg.
`default_nettype none

module r2cov_datapath #(
    parameter int MAX_SYNDROME_BITS = r2cov_pkg::MaxSyndromeBits,
    parameter int MAX_COLUMNS       = r2cov_pkg::MaxColumns
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  r2cov_pkg::cmd_t                    cmd,
    output r2cov_pkg::stat_t                   st,
    input  wire [r2cov_pkg::RedundW-1:0]       cfg_redund,
    input  wire [r2cov_pkg::ColCountW-1:0]     cfg_colcnt,
    input  wire [r2cov_pkg::ModeW-1:0]         cfg_mode,
    input  wire [1:0]                          in_req,
    input  wire [r2cov_pkg::SlotW-1:0]         in_slot,
    input  wire [r2cov_pkg::ColumnW-1:0]       in_column,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [87:0]                        out_data
);
    import r2cov_pkg::*;

    localparam int SB    = MAX_SYNDROME_BITS;
    localparam int Depth = 1 << SB;
    localparam int LW    = $clog2(MAX_COLUMNS + 1);
    localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    // Memories.
    logic [CountW-1:0] cnt_mem  [Depth];
    logic              flag_mem [Depth];
    logic [SB-1:0]     col_mem  [MAX_COLUMNS];

    // Request and geometry.
    req_t               req_reg;
    logic [SlotW-1:0]   slot_reg;
    logic [ColumnW-1:0] col_reg;
    logic [RedundW-1:0] used_r_reg;
    logic [LW-1:0]      used_n_reg;
    logic [LW-1:0]      loaded_reg;
    logic [TotalW-1:0]  uncov_reg;
    logic [TotalW-1:0]  single_reg;
    logic [SB-1:0]      clr_addr_reg;

    // Read data and sweep state.
    logic               flag_q_reg;
    logic [SB-1:0]      store_q_reg;
    logic [CountW-1:0]  cnt_q_reg;
    logic [SB-1:0]      syn_reg;
    logic               bump_en_reg;
    logic [SB-1:0]      c_reg;
    logic               up_reg;
    logic [LW-1:0]      limit_reg;
    logic               skip_en_reg;
    logic [LW-1:0]      idx_reg;
    logic [SB-1:0]      removed_reg;
    status_t            status_reg;

    // Result register.
    logic               out_valid_reg;
    logic [87:0]        out_data_reg;

    logic [RedundW-1:0] r_clamp;
    logic [LW-1:0]      n_clamp;
    logic               col_bad;
    status_t            code;
    logic [SB-1:0]      cnt_rd_addr;
    logic [CW-1:0]      col_rd_addr;
    logic [LW-1:0]      idx_plus;
    logic [CountW-1:0]  cnt_after;
    logic               cnt_we;
    logic [TotalW-1:0]  uncov_next;
    logic [TotalW-1:0]  single_next;
    logic [23:0]        obj_wide;
    logic [CW-1:0]      store_wr_addr;
    logic [LW-1:0]      slot_ext;

    // Geometry clamping for a clear.
    always_comb
    begin
        if (cfg_redund < MinRedund)
        begin
            r_clamp = MinRedund;
        end
        else if (32'(cfg_redund) > SB)
        begin
            r_clamp = RedundW'(SB);
        end
        else
        begin
            r_clamp = cfg_redund;
        end
        if (32'(cfg_colcnt) > MAX_COLUMNS)
        begin
            n_clamp = LW'(MAX_COLUMNS);
        end
        else
        begin
            n_clamp = LW'(cfg_colcnt);
        end
    end

    // Request checks in priority order.
    assign col_bad = (col_reg == '0) || ((32'(col_reg) >> used_r_reg) != 32'd0);

    always_comb
    begin
        code = STS_OK;
        unique case (req_reg)
            REQ_LOAD:
            begin
                priority if (loaded_reg >= used_n_reg) code = STS_PHASE;
                else if (col_bad)                       code = STS_BAD_COLUMN;
                else if (flag_q_reg)                    code = STS_DUPLICATE;
                else                                    code = STS_OK;
            end
            REQ_SWAP:
            begin
                priority if (loaded_reg != used_n_reg)          code = STS_PHASE;
                else if (32'(slot_reg) >= 32'(used_n_reg))      code = STS_BAD_SLOT;
                else if (col_bad)                               code = STS_BAD_COLUMN;
                else if (flag_q_reg)                            code = STS_DUPLICATE;
                else                                            code = STS_OK;
            end
            default: code = STS_OK;
        endcase
    end

    assign idx_plus    = idx_reg + 1'b1;
    assign slot_ext    = LW'(slot_reg);
    assign cnt_rd_addr = cmd.cnt_rd_self ? c_reg : (c_reg ^ store_q_reg);
    always_comb
    begin
        if (cmd.chk_rd)
        begin
            col_rd_addr = CW'(slot_reg);
        end
        else if (cmd.idx_adv)
        begin
            col_rd_addr = idx_plus[CW-1:0];
        end
        else
        begin
            col_rd_addr = idx_reg[CW-1:0];
        end
    end
    assign store_wr_addr = (req_reg == REQ_SWAP) ? slot_ext[CW-1:0] : loaded_reg[CW-1:0];

    // One count step: new count value and total updates.
    always_comb
    begin
        cnt_after   = cnt_q_reg;
        cnt_we      = 1'b0;
        uncov_next  = uncov_reg;
        single_next = single_reg;
        if (bump_en_reg)
        begin
            if (up_reg)
            begin
                cnt_after = cnt_q_reg + 1'b1;
                cnt_we    = 1'b1;
                if (cnt_q_reg == CountW'(0))
                begin
                    uncov_next  = uncov_reg - 1'b1;
                    single_next = single_reg + 1'b1;
                end
                else if (cnt_q_reg == CountW'(1))
                begin
                    single_next = single_reg - 1'b1;
                end
            end
            else if (cnt_q_reg != CountW'(0))
            begin
                cnt_after = cnt_q_reg - 1'b1;
                cnt_we    = 1'b1;
                if (cnt_q_reg == CountW'(1))
                begin
                    uncov_next  = uncov_reg + 1'b1;
                    single_next = single_reg - 1'b1;
                end
                else if (cnt_q_reg == CountW'(2))
                begin
                    single_next = single_reg + 1'b1;
                end
            end
        end
    end

    // Count memory: clearing pass, read and write-back.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            cnt_mem[clr_addr_reg] <= (clr_addr_reg == '0) ? CountW'(1) : CountW'(0);
        end
        else if (cmd.cnt_wr && cnt_we)
        begin
            cnt_mem[syn_reg] <= cnt_after;
        end
        if (cmd.cnt_rd_self || cmd.cnt_rd_pair)
        begin
            cnt_q_reg <= cnt_mem[cnt_rd_addr];
        end
    end

    // Membership flag memory.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            flag_mem[clr_addr_reg] <= 1'b0;
        end
        else if (cmd.flag_clr)
        begin
            flag_mem[removed_reg] <= 1'b0;
        end
        else if (cmd.flag_set)
        begin
            flag_mem[col_reg[SB-1:0]] <= 1'b1;
        end
        if (cmd.chk_rd)
        begin
            flag_q_reg <= flag_mem[col_reg[SB-1:0]];
        end
    end

    // Column store.
    always_ff @(posedge clk)
    begin
        if (cmd.flag_set)
        begin
            col_mem[store_wr_addr] <= col_reg[SB-1:0];
        end
        if (cmd.chk_rd || cmd.cnt_wr)
        begin
            store_q_reg <= col_mem[col_rd_addr];
        end
    end

    // Payload registers of a sweep step.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            slot_reg <= in_slot;
            col_reg  <= in_column;
        end
        if (cmd.cnt_rd_self || cmd.cnt_rd_pair)
        begin
            syn_reg     <= cnt_rd_addr;
            bump_en_reg <= cmd.cnt_rd_self ||
                           !(skip_en_reg && (32'(idx_reg) == 32'(slot_reg)));
        end
        if (cmd.sweep_rem)
        begin
            c_reg <= store_q_reg;
        end
        else if (cmd.sweep_new)
        begin
            c_reg <= col_reg[SB-1:0];
        end
    end

    // Control registers: request, geometry, totals and sweep counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg      <= REQ_CLEAR;
            used_r_reg   <= '0;
            used_n_reg   <= '0;
            loaded_reg   <= '0;
            uncov_reg    <= '0;
            single_reg   <= '0;
            clr_addr_reg <= '0;
            up_reg       <= 1'b1;
            limit_reg    <= '0;
            skip_en_reg  <= 1'b0;
            idx_reg      <= '0;
            removed_reg  <= '0;
            status_reg   <= STS_OK;
        end
        else
        begin
            if (cmd.latch_req)
            begin
                req_reg <= req_t'(in_req);
            end
            if (cmd.clr_start)
            begin
                used_r_reg   <= r_clamp;
                used_n_reg   <= n_clamp;
                loaded_reg   <= '0;
                uncov_reg    <= (TotalW'(1) << r_clamp) - 1'b1;
                single_reg   <= TotalW'(1);
                clr_addr_reg <= '0;
                status_reg   <= STS_OK;
                removed_reg  <= '0;
                up_reg       <= 1'b1;
            end
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.decide)
            begin
                status_reg  <= code;
                removed_reg <= (req_reg == REQ_SWAP && code == STS_OK) ? store_q_reg : '0;
            end
            if (cmd.sweep_rem)
            begin
                up_reg      <= 1'b0;
                limit_reg   <= used_n_reg;
                skip_en_reg <= 1'b1;
                idx_reg     <= '0;
            end
            else if (cmd.sweep_new)
            begin
                up_reg      <= 1'b1;
                limit_reg   <= (req_reg == REQ_SWAP) ? used_n_reg : loaded_reg;
                skip_en_reg <= (req_reg == REQ_SWAP);
                idx_reg     <= '0;
            end
            if (cmd.cnt_wr)
            begin
                uncov_reg  <= uncov_next;
                single_reg <= single_next;
            end
            if (cmd.idx_adv)
            begin
                idx_reg <= idx_plus;
            end
            if (cmd.flag_set && req_reg == REQ_LOAD)
            begin
                loaded_reg <= loaded_reg + 1'b1;
            end
        end
    end

    // Objective chosen by mode.
    always_comb
    begin
        if (cfg_mode == MODE_MISS_A || cfg_mode == MODE_MISS_B)
        begin
            obj_wide = 24'(uncov_reg);
        end
        else if (cfg_mode == MODE_SCALE4_A || cfg_mode == MODE_SCALE4_B)
        begin
            obj_wide = (24'(uncov_reg) << ScaleLowShift) + 24'(single_reg);
        end
        else
        begin
            obj_wide = (24'(uncov_reg) << ScaleHighShift) + 24'(single_reg);
        end
    end

    // Result register; it frees up in the cycle its transfer completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {3'b000,
                             ColumnW'(removed_reg),
                             LoadedW'(loaded_reg),
                             obj_wide[ObjW-1:0],
                             single_reg,
                             uncov_reg[ColumnW-1:0],
                             status_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign st.clr_last  = (clr_addr_reg == SB'(Depth - 1));
    assign st.pair_done = (idx_reg >= limit_reg);
    assign st.phase_rem = !up_reg;
    assign st.out_free  = !out_valid_reg || out_ready;
    assign st.req       = req_reg;
    assign st.code      = code;

endmodule

`default_nettype wire

>>> src/radius2_coverage_count_engine_unit.sv
// Top level of the radius-2 coverage count engine: configuration registers
// and the controller and datapath. Depends on r2cov_pkg, r2cov_ctrl, r2cov_datapath.
//
// Usage: requests arrive on the s_axis channel (kind in tuser, slot and column
// in tdata); every request gives exactly one result transfer on m_axis.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data while idle;
// redundancy and column count take effect at the next clear, mode at the next result.
// Timing is set by the single-port count memory, one read-modify-write per
// syndrome update: a query or rejected request makes no update; a load with
// k columns already stored updates the new column alone and paired with each
// of the k; a swap in a full set of n columns sweeps the removed column down
// and the new one up, each alone and paired with the n columns but its slot;
// a clear is a sweep over the count and flag memories, one entry per cycle.
// One request is worked on at a time; s_axis_tready is high only when idle.
// After reset the same clearing pass runs before s_axis_tready first rises,
// with the registers at their reset values.
// The result sits in an output register: a stalled receiver holds it, and the
// next request is accepted meanwhile, finishing only once the register frees.
`default_nettype none

module radius2_coverage_count_engine_unit #(
    parameter int MAX_SYNDROME_BITS = r2cov_pkg::MaxSyndromeBits,
    parameter int MAX_COLUMNS       = r2cov_pkg::MaxColumns
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_wr_en,
    input  wire  [1:0]  cfg_index,
    input  wire  [9:0]  cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // slot [8:0], column [24:9], zero fill [31:25]
    input  wire  [31:0] s_axis_tdata,
    // req_type [1:0]
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // status [2:0], missing_count [18:3], singleton_count [35:19],
    // objective_value [58:36], loaded_count [68:59], removed_column [84:69],
    // zero fill [87:85]
    output logic [87:0] m_axis_tdata
);
    import r2cov_pkg::*;

    logic [RedundW-1:0]   redund_reg;
    logic [ColCountW-1:0] colcnt_reg;
    logic [ModeW-1:0]     mode_reg;
    cmd_t                 cmd;
    stat_t                st;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            redund_reg <= RedundReset;
            colcnt_reg <= ColCountReset;
            mode_reg   <= ModeReset;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_REDUNDANCY:     redund_reg <= cfg_data[RedundW-1:0];
                REG_COLUMN_COUNT:   colcnt_reg <= cfg_data[ColCountW-1:0];
                REG_OBJECTIVE_MODE: mode_reg   <= cfg_data[ModeW-1:0];
                default:            redund_reg <= redund_reg;
            endcase
        end
    end

    r2cov_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    r2cov_datapath #(
        .MAX_SYNDROME_BITS (MAX_SYNDROME_BITS),
        .MAX_COLUMNS       (MAX_COLUMNS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .cfg_redund (redund_reg),
        .cfg_colcnt (colcnt_reg),
        .cfg_mode   (mode_reg),
        .in_req     (s_axis_tuser),
        .in_slot    (s_axis_tdata[8:0]),
        .in_column  (s_axis_tdata[24:9]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for radius2_coverage_count_engine_unit: directed rows,
// then random request streams under several geometries, idling and stall patterns.
// Depends on r2cov_pkg and the RTL of the engine only.
`timescale 1ns / 1ps

module testbench;
    import r2cov_pkg::*;

    localparam int QuietLimit = 300000;
    localparam int SynDepth   = 65536;

    typedef struct packed {
        status_t      code;
        logic [15:0]  missing;
        logic [16:0]  singles;
        logic [22:0]  score;
        logic [9:0]   loaded;
        logic [15:0]  removed;
    } outcome_t;

    typedef struct packed {
        logic         is_cfg;
        req_t         kind;
        logic [8:0]   slot;
        logic [15:0]  column;
        logic         typed;
        outcome_t     want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [9:0]  cfg_data;
    logic        s_valid;
    logic        s_axis_tready;
    logic [31:0] s_data;
    logic [1:0]  s_user;
    logic        m_axis_tvalid;
    logic        m_ready;
    logic [87:0] m_axis_tdata;

    radius2_coverage_count_engine_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow state of the engine.
    int          cov_cnt [SynDepth];
    bit          is_member [SynDepth];
    logic [15:0] col_mem [MaxColumns];
    int          miss_tot;
    int          single_tot;
    int          n_loaded;
    int          geo_bits;
    int          geo_cols;
    int          reg_redund;
    int          reg_cols;
    int          reg_mode;

    outcome_t    pending_q[$];
    row_t        dir_q[$];
    int          errors;
    int          send_idle;
    int          recv_stall;
    bit          hold_req;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Restart the coverage set with the latched geometry.
    function automatic void geo_clear();
        geo_bits = (reg_redund < 3) ? 3 : ((reg_redund > 16) ? 16 : reg_redund);
        geo_cols = (reg_cols > MaxColumns) ? MaxColumns : reg_cols;
        for (int i = 0; i < SynDepth; i++)
        begin
            cov_cnt[i] = 0;
            is_member[i] = 1'b0;
        end
        cov_cnt[0] = 1;
        miss_tot = (1 << geo_bits) - 1;
        single_tot = 1;
        n_loaded = 0;
    endfunction

    // Move one syndrome count up or down and keep the totals in step.
    function automatic void tally(int syn, bit up);
        int was;
        int now;
        was = cov_cnt[syn & 16'hFFFF];
        if (!up && was == 0)
            return;
        now = up ? was + 1 : was - 1;
        if (was == 0 && now == 1)
        begin
            miss_tot--;
            single_tot++;
        end
        else if (was == 1 && now == 0)
        begin
            miss_tot++;
            single_tot--;
        end
        else if (was == 1 && now == 2)
            single_tot--;
        else if (was == 2 && now == 1)
            single_tot++;
        cov_cnt[syn & 16'hFFFF] = now;
    endfunction

    // Add or remove a column alone and paired with every stored column but the skipped slot.
    function automatic void sweep_pair(int c, int limit, int skip, bit up);
        tally(c, up);
        for (int i = 0; i < limit && i < MaxColumns; i++)
            if (i != skip)
                tally(c ^ col_mem[i], up);
    endfunction

    function automatic outcome_t predict_request(req_t kind, int slot, int column);
        outcome_t res;
        int       space;
        int       gone;
        longint   score;
        space = 1 << geo_bits;
        gone = 0;
        res.code = STS_OK;
        case (kind)
            REQ_CLEAR: geo_clear();
            REQ_LOAD:
            begin
                if (n_loaded >= geo_cols)
                    res.code = STS_PHASE;
                else if (column == 0 || column >= space)
                    res.code = STS_BAD_COLUMN;
                else if (is_member[column])
                    res.code = STS_DUPLICATE;
                else
                begin
                    sweep_pair(column, n_loaded, MaxColumns, 1'b1);
                    is_member[column] = 1'b1;
                    col_mem[n_loaded] = column;
                    n_loaded++;
                end
            end
            REQ_SWAP:
            begin
                if (n_loaded != geo_cols)
                    res.code = STS_PHASE;
                else if (slot >= geo_cols)
                    res.code = STS_BAD_SLOT;
                else if (column == 0 || column >= space)
                    res.code = STS_BAD_COLUMN;
                else if (is_member[column])
                    res.code = STS_DUPLICATE;
                else
                begin
                    gone = col_mem[slot];
                    sweep_pair(gone, geo_cols, slot, 1'b0);
                    sweep_pair(column, geo_cols, slot, 1'b1);
                    is_member[gone] = 1'b0;
                    is_member[column] = 1'b1;
                    col_mem[slot] = column;
                end
            end
            default: ;
        endcase
        if (reg_mode == MODE_MISS_A || reg_mode == MODE_MISS_B)
            score = miss_tot;
        else if (reg_mode == MODE_SCALE4_A || reg_mode == MODE_SCALE4_B)
            score = 16 * longint'(miss_tot) + single_tot;
        else
            score = 64 * longint'(miss_tot) + single_tot;
        res.missing = miss_tot[15:0];
        res.singles = single_tot[16:0];
        res.score   = score[22:0];
        res.loaded  = n_loaded[9:0];
        res.removed = gone[15:0];
        return res;
    endfunction

    // Offer one request and wait for its transfer; the expectation is queued on acceptance.
    task automatic send_request(req_t kind, int slot, int column, bit typed, outcome_t want);
        outcome_t got;
        if ($urandom_range(99) < send_idle)
        begin
            s_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= kind;
        s_data  <= {7'b0, column[15:0], slot[8:0]};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        got = predict_request(kind, slot, column);
        pending_q.push_back(typed ? want : got);
    endtask

    task automatic send_plain(req_t kind, int slot, int column);
        send_request(kind, slot, column, 1'b0, '0);
    endtask

    // Let every result come back, then give the engine time to settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[9:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_REDUNDANCY:   reg_redund = value & 5'h1F;
            REG_COLUMN_COUNT: reg_cols = value & 10'h3FF;
            default:          reg_mode = value & 3'h7;
        endcase
    endtask

    function automatic row_t row_req(req_t kind, int slot, int column);
        row_t row;
        row = '0;
        row.kind = kind;
        row.slot = slot[8:0];
        row.column = column[15:0];
        return row;
    endfunction

    function automatic row_t row_exp(req_t kind, int slot, int column, status_t code,
                                     int missing, int singles, int score, int loaded);
        row_t row;
        row = row_req(kind, slot, column);
        row.typed = 1'b1;
        row.want = '{code, missing[15:0], singles[16:0], score[22:0], loaded[9:0], 16'h0};
        return row;
    endfunction

    function automatic row_t row_cfg(int idx, int value);
        row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.slot = idx[8:0];
        row.column = value[15:0];
        return row;
    endfunction

    // One random phase: new geometry, a clear, a fill of the set, then swaps and noise.
    task automatic run_phase(int redund, int cols, int mode, int swaps,
                             int s_pct, int r_pct, bit squeeze);
        int top;
        int pick;
        drain();
        write_reg(REG_REDUNDANCY, redund);
        write_reg(REG_COLUMN_COUNT, cols);
        write_reg(REG_OBJECTIVE_MODE, mode);
        send_idle = s_pct;
        recv_stall = r_pct;
        send_plain(REQ_CLEAR, 0, 0);
        top = (1 << geo_bits) - 1;
        while (n_loaded < geo_cols)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_plain(REQ_LOAD, 0, $urandom_range(65535));
            else if (pick < 12)
                send_plain(REQ_SWAP, $urandom_range(511), $urandom_range(1, top));
            else
                send_plain(REQ_LOAD, 0, $urandom_range(1, top));
        end
        if (squeeze)
            hold_req = 1'b1;
        for (int i = 0; i < swaps; i++)
        begin
            pick = $urandom_range(99);
            if (squeeze && i < 12)
                send_plain(REQ_QUERY, $urandom_range(511), $urandom_range(65535));
            else if (pick < 65)
                send_plain(REQ_SWAP, $urandom_range(geo_cols > 0 ? geo_cols - 1 : 0),
                           $urandom_range(1, top));
            else if (pick < 75)
                send_plain(REQ_QUERY, $urandom_range(511), $urandom_range(65535));
            else if (pick < 85)
                send_plain(REQ_SWAP, $urandom_range(511), $urandom_range(65535));
            else
                send_plain(REQ_LOAD, $urandom_range(511), $urandom_range(65535));
        end
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Result side: check every transfer against the oldest expectation, then pick tready.
    always @(posedge clk or negedge rst_n)
    begin
        int       hold_left;
        outcome_t want;
        if (!rst_n)
        begin
            m_ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_ready)
            begin
                if (pending_q.size() == 0)
                begin
                    $display("%0t: result transfer with no expectation waiting, %s, actual %h",
                             $time, "expected none", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    check_field("status", want.code, m_axis_tdata[2:0]);
                    check_field("missing_count", want.missing, m_axis_tdata[18:3]);
                    check_field("singleton_count", want.singles, m_axis_tdata[35:19]);
                    check_field("objective_value", want.score, m_axis_tdata[58:36]);
                    check_field("loaded_count", want.loaded, m_axis_tdata[68:59]);
                    check_field("removed_column", want.removed, m_axis_tdata[84:69]);
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_ready <= 1'b0;
            end
            else
                m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        int quiet;
        if (!rst_n || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QuietLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        row_t row;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        s_user = REQ_QUERY;
        errors = 0;
        send_idle = 0;
        recv_stall = 0;
        hold_req = 1'b0;
        reg_redund = RedundReset;
        reg_cols = ColCountReset;
        reg_mode = ModeReset;
        geo_clear();
        for (int i = 0; i < MaxColumns; i++)
            col_mem[i] = '0;

        // Directed rows: reset state first, then a tiny full set of three columns.
        dir_q.push_back(row_exp(REQ_QUERY, 0, 0, STS_OK, 2047, 1, 2047, 0));
        dir_q.push_back(row_exp(REQ_SWAP, 0, 5, STS_PHASE, 2047, 1, 2047, 0));
        dir_q.push_back(row_exp(REQ_LOAD, 0, 0, STS_BAD_COLUMN, 2047, 1, 2047, 0));
        dir_q.push_back(row_exp(REQ_LOAD, 0, 2048, STS_BAD_COLUMN, 2047, 1, 2047, 0));
        dir_q.push_back(row_exp(REQ_LOAD, 0, 1, STS_OK, 2046, 2, 2046, 1));
        dir_q.push_back(row_exp(REQ_LOAD, 0, 1, STS_DUPLICATE, 2046, 2, 2046, 1));
        dir_q.push_back(row_exp(REQ_LOAD, 511, 16'hFFFF, STS_BAD_COLUMN, 2046, 2, 2046, 1));
        dir_q.push_back(row_cfg(REG_REDUNDANCY, 3));
        dir_q.push_back(row_cfg(REG_COLUMN_COUNT, 3));
        dir_q.push_back(row_cfg(REG_OBJECTIVE_MODE, 1));
        dir_q.push_back(row_exp(REQ_CLEAR, 0, 0, STS_OK, 7, 1, 113, 0));
        dir_q.push_back(row_req(REQ_LOAD, 0, 1));
        dir_q.push_back(row_req(REQ_LOAD, 0, 2));
        dir_q.push_back(row_req(REQ_LOAD, 0, 4));
        dir_q.push_back(row_req(REQ_LOAD, 0, 5));
        dir_q.push_back(row_req(REQ_SWAP, 3, 5));
        dir_q.push_back(row_req(REQ_SWAP, 511, 5));
        dir_q.push_back(row_req(REQ_SWAP, 0, 0));
        dir_q.push_back(row_req(REQ_SWAP, 0, 8));
        dir_q.push_back(row_req(REQ_SWAP, 0, 2));
        dir_q.push_back(row_req(REQ_SWAP, 0, 1));
        dir_q.push_back(row_req(REQ_SWAP, 0, 7));
        dir_q.push_back(row_req(REQ_QUERY, 0, 0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_q[i])
        begin
            row = dir_q[i];
            if (row.is_cfg)
            begin
                drain();
                write_reg(row.slot[1:0], row.column);
            end
            else
                send_request(row.kind, row.slot, row.column, row.typed, row.want);
        end

        // Random phases over geometry, objective mode and handshake pressure.
        run_phase(0, 0, 2, 20, 0, 0, 1'b0);
        run_phase(4, 10, 3, 80, 73, 0, 1'b0);
        run_phase(5, 12, 4, 90, 0, 73, 1'b1);
        run_phase(6, 16, 5, 90, 7, 7, 1'b0);
        run_phase(3, 7, 6, 60, 0, 0, 1'b0);
        run_phase(31, 60, 7, 60, 0, 0, 1'b0);

        drain();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
